### hdl/mvp_pkg.sv
// ----------------------------------------------------------------------------
// mvp_pkg
// Shared types and constants of the real matrix by complex vector product core.
// ----------------------------------------------------------------------------
package mvp_pkg;

   // Field widths.
   localparam int CMD_W     = 2;
   localparam int IDX_W     = 4;
   localparam int VAL_W     = 16;
   localparam int PROD_W    = 2 * VAL_W;
   localparam int ACC_W     = 38;
   localparam int SIZE_W    = 5;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = SIZE_W;

   // Default store dimension and the largest size the 4-bit indexes can reach.
   localparam int DEFAULT_MAX_SIZE = 16;
   localparam int INDEX_LIMIT      = 16;
   localparam int SIZE_RESET       = 16;

   // Request commands.
   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_MATRIX = 2'd0,
      CMD_LOAD_VECTOR = 2'd1,
      CMD_COMPUTE     = 2'd2
   } cmd_type;

   // Control register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIZE_IN_USE    = 1'b0,
      CSR_TRANSPOSE_MODE = 1'b1
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             load_matrix;
      logic             load_vector;
      logic             mac_valid;
      logic             mac_first;
      logic             mac_last_col;
      logic             mac_last_row;
      logic [IDX_W-1:0] mac_row;
      logic [IDX_W-1:0] mac_col;
      logic             transpose;
      logic             copy_valid;
      logic [IDX_W-1:0] copy_idx;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic row_taken;
   } dp_status_type;

endpackage

### hdl/mvp_req_if.sv
// ----------------------------------------------------------------------------
// mvp_req_if
// Request channel: load a matrix entry, load a vector entry, or compute.
// ----------------------------------------------------------------------------
interface mvp_req_if;
   logic                                valid;
   logic                                ready;
   logic        [mvp_pkg::CMD_W-1:0]    cmd;
   logic        [mvp_pkg::IDX_W-1:0]    row_index;
   logic        [mvp_pkg::IDX_W-1:0]    col_index;
   logic signed [mvp_pkg::VAL_W-1:0]    value_re;
   logic signed [mvp_pkg::VAL_W-1:0]    value_im;

   modport source (output valid, cmd, row_index, col_index, value_re, value_im,
                   input ready);
   modport sink   (input valid, cmd, row_index, col_index, value_re, value_im,
                   output ready);
endinterface

### hdl/mvp_rsp_if.sv
// ----------------------------------------------------------------------------
// mvp_rsp_if
// Response channel: one complex result element per matrix row.
// ----------------------------------------------------------------------------
interface mvp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [mvp_pkg::IDX_W-1:0]    out_index;
   logic signed [mvp_pkg::ACC_W-1:0]    out_re;
   logic signed [mvp_pkg::ACC_W-1:0]    out_im;
   logic                                out_last;

   modport source (output valid, out_index, out_re, out_im, out_last,
                   input ready);
   modport sink   (input valid, out_index, out_re, out_im, out_last,
                   output ready);
endinterface

### hdl/mvp_ctrl.sv
// ----------------------------------------------------------------------------
// mvp_ctrl
// Controller: control registers, request acceptance and the sequencing of
// row multiply-accumulate runs and the vector write-back sweep.
// ----------------------------------------------------------------------------
module mvp_ctrl #(
   parameter int MAX_SIZE = mvp_pkg::DEFAULT_MAX_SIZE
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic [mvp_pkg::CMD_W-1:0]          req_cmd,
   output logic                               req_ready,
   input  logic                               csr_write_enable,
   input  logic [mvp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mvp_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output mvp_pkg::ctl_cmd_type               cmd,
   input  mvp_pkg::dp_status_type             status
);

   localparam int LIM = (MAX_SIZE < mvp_pkg::INDEX_LIMIT) ? MAX_SIZE
                                                           : mvp_pkg::INDEX_LIMIT;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ISSUE = 5'b00010,
      ST_WAIT  = 5'b00100,
      ST_COPY  = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   state_type                        state_ff, state_in;
   logic [mvp_pkg::SIZE_W-1:0]       size_ff, size_in;
   logic                             transpose_ff, transpose_in;
   logic [mvp_pkg::SIZE_W-1:0]       n_ff, n_in;
   logic [mvp_pkg::IDX_W-1:0]        row_ff, row_in;
   logic [mvp_pkg::IDX_W-1:0]        col_ff, col_in;
   logic [mvp_pkg::SIZE_W-1:0]       n_eff;
   logic [mvp_pkg::SIZE_W-1:0]       n_last;
   logic                             accept;
   logic                             col_is_last;
   logic                             row_is_last;

   // Size in use, clipped to what the stores and indexes can hold.
   assign n_eff = (size_ff > mvp_pkg::SIZE_W'(LIM)) ? mvp_pkg::SIZE_W'(LIM) : size_ff;
   assign n_last = n_ff - mvp_pkg::SIZE_W'(1);
   assign col_is_last = ({1'b0, col_ff} == n_last);
   assign row_is_last = ({1'b0, row_ff} == n_last);

   // A request is taken only while no compute is in progress.
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Control register writes.
   always_comb begin
      size_in      = size_ff;
      transpose_in = transpose_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            mvp_pkg::CSR_SIZE_IN_USE:    size_in      = csr_write_data;
            mvp_pkg::CSR_TRANSPOSE_MODE: transpose_in = csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == mvp_pkg::CMD_COMPUTE) &&
                (n_eff != mvp_pkg::SIZE_W'(0))) begin
               n_in     = n_eff;
               row_in   = '0;
               col_in   = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (col_is_last) begin
               col_in   = '0;
               state_in = ST_WAIT;
            end else begin
               col_in = col_ff + mvp_pkg::IDX_W'(1);
            end
         end
         ST_WAIT: begin
            if (status.row_taken) begin
               if (row_is_last) begin
                  col_in   = '0;
                  state_in = ST_COPY;
               end else begin
                  row_in   = row_ff + mvp_pkg::IDX_W'(1);
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_COPY: begin
            if (col_is_last) begin
               state_in = ST_FLUSH;
            end else begin
               col_in = col_ff + mvp_pkg::IDX_W'(1);
            end
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd              = '0;
      cmd.load_matrix  = accept && (req_cmd == mvp_pkg::CMD_LOAD_MATRIX);
      cmd.load_vector  = accept && (req_cmd == mvp_pkg::CMD_LOAD_VECTOR);
      cmd.mac_valid    = (state_ff == ST_ISSUE);
      cmd.mac_first    = (col_ff == '0);
      cmd.mac_last_col = col_is_last;
      cmd.mac_last_row = row_is_last;
      cmd.mac_row      = row_ff;
      cmd.mac_col      = col_ff;
      cmd.transpose    = transpose_ff;
      cmd.copy_valid   = (state_ff == ST_COPY);
      cmd.copy_idx     = col_ff;
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= mvp_pkg::SIZE_W'(mvp_pkg::SIZE_RESET);
         transpose_ff <= 1'b0;
         n_ff         <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         transpose_ff <= transpose_in;
         n_ff         <= n_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
      end
   end

   // A row run never goes past the active size.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> ({1'b0, row_ff} < n_ff) && ({1'b0, col_ff} < n_ff))
      else $error("mvp_ctrl: issue index beyond active size");

   // Multiply-accumulate and write-back sweep never overlap.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.mac_valid && cmd.copy_valid))
      else $error("mvp_ctrl: mac and copy issued together");

   // Hand-off of the final row starts the write-back sweep.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT && status.row_taken && row_is_last) |=> (state_ff == ST_COPY))
      else $error("mvp_ctrl: write-back did not follow the final row");

endmodule

### hdl/mvp_datapath.sv
// ----------------------------------------------------------------------------
// mvp_datapath
// Datapath: matrix and vector memories, a three-stage multiply-accumulate
// pipeline, the response register and the rounded write-back staging store.
// ----------------------------------------------------------------------------
module mvp_datapath #(
   parameter int MAX_SIZE = mvp_pkg::DEFAULT_MAX_SIZE
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mvp_pkg::ctl_cmd_type               cmd,
   output mvp_pkg::dp_status_type             status,
   input  logic        [mvp_pkg::IDX_W-1:0]   req_row_index,
   input  logic        [mvp_pkg::IDX_W-1:0]   req_col_index,
   input  logic signed [mvp_pkg::VAL_W-1:0]   req_value_re,
   input  logic signed [mvp_pkg::VAL_W-1:0]   req_value_im,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic        [mvp_pkg::IDX_W-1:0]   rsp_out_index,
   output logic signed [mvp_pkg::ACC_W-1:0]   rsp_out_re,
   output logic signed [mvp_pkg::ACC_W-1:0]   rsp_out_im,
   output logic                               rsp_out_last
);

   localparam int LIM       = (MAX_SIZE < mvp_pkg::INDEX_LIMIT) ? MAX_SIZE
                                                                 : mvp_pkg::INDEX_LIMIT;
   localparam int MAT_DEPTH = MAX_SIZE * MAX_SIZE;
   localparam int AW        = $clog2(MAT_DEPTH);
   localparam int VW        = $clog2(MAX_SIZE);
   localparam int SW        = $clog2(LIM);
   localparam int VAL_W     = mvp_pkg::VAL_W;
   localparam int PROD_W    = mvp_pkg::PROD_W;
   localparam int ACC_W     = mvp_pkg::ACC_W;
   localparam int IDX_W     = mvp_pkg::IDX_W;

   // Round Q14.24 to Q4.12 half up and saturate to 16 bits.
   function automatic logic signed [VAL_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W:0]       biased;
      logic signed [ACC_W-12:0]    q;
      logic signed [VAL_W-1:0]     r;
      biased = {a[ACC_W-1], a} + (ACC_W+1)'(2048);
      q      = biased[ACC_W:12];
      if (q > (ACC_W-11)'(32767)) begin
         r = 16'sh7fff;
      end else if (q < -(ACC_W-11)'(32768)) begin
         r = 16'sh8000;
      end else begin
         r = q[VAL_W-1:0];
      end
      return r;
   endfunction

   // Memories.
   logic signed [VAL_W-1:0]     matrix_mem [MAT_DEPTH];
   logic signed [VAL_W-1:0]     vec_re_mem [MAX_SIZE];
   logic signed [VAL_W-1:0]     vec_im_mem [MAX_SIZE];
   logic signed [2*VAL_W-1:0]   stage_mem  [LIM];

   // Address and write-port selection.
   logic [AW-1:0]               mat_wr_addr;
   logic [AW-1:0]               mat_rd_addr;
   logic                        mat_wr_en;
   logic                        load_row_ok;
   logic                        load_col_ok;
   logic [IDX_W-1:0]            mac_major;
   logic [IDX_W-1:0]            mac_minor;
   logic                        vec_wr_en;
   logic [VW-1:0]               vec_wr_addr;
   logic signed [VAL_W-1:0]     vec_wr_re;
   logic signed [VAL_W-1:0]     vec_wr_im;

   // Pipeline stage A: memory read data.
   logic signed [VAL_W-1:0]     a_m_ff;
   logic signed [VAL_W-1:0]     a_vre_ff;
   logic signed [VAL_W-1:0]     a_vim_ff;
   logic                        a_valid_ff;
   logic                        a_first_ff;
   logic                        a_last_col_ff;
   logic                        a_last_row_ff;
   logic [IDX_W-1:0]            a_row_ff;

   // Pipeline stage B: products.
   logic signed [PROD_W-1:0]    b_pre_ff;
   logic signed [PROD_W-1:0]    b_pim_ff;
   logic                        b_valid_ff;
   logic                        b_first_ff;
   logic                        b_last_col_ff;
   logic                        b_last_row_ff;
   logic [IDX_W-1:0]            b_row_ff;

   // Accumulator stage.
   logic signed [ACC_W-1:0]     acc_re_ff, acc_re_in;
   logic signed [ACC_W-1:0]     acc_im_ff, acc_im_in;
   logic                        acc_done_ff, acc_done_in;
   logic                        acc_last_row_ff;
   logic [IDX_W-1:0]            acc_row_ff;
   logic                        transfer;

   // Response register.
   logic                        out_valid_ff, out_valid_in;
   logic [IDX_W-1:0]            out_index_ff;
   logic signed [ACC_W-1:0]     out_re_ff;
   logic signed [ACC_W-1:0]     out_im_ff;
   logic                        out_last_ff;

   // Write-back sweep.
   logic signed [2*VAL_W-1:0]   cp_data_ff;
   logic                        cp_valid_ff;
   logic [IDX_W-1:0]            cp_idx_ff;

   // Loads outside the store are dropped.
   assign load_row_ok = (32'(req_row_index) < MAX_SIZE);
   assign load_col_ok = (32'(req_col_index) < MAX_SIZE);
   assign mat_wr_en   = cmd.load_matrix && load_row_ok && load_col_ok;
   assign mat_wr_addr = AW'(32'(req_row_index) * MAX_SIZE + 32'(req_col_index));

   // Transpose mode swaps the roles of row and column in the matrix address.
   assign mac_major   = cmd.transpose ? cmd.mac_col : cmd.mac_row;
   assign mac_minor   = cmd.transpose ? cmd.mac_row : cmd.mac_col;
   assign mat_rd_addr = AW'(32'(mac_major) * MAX_SIZE + 32'(mac_minor));

   // The vector write port serves loads and the write-back sweep.
   always_comb begin
      if (cp_valid_ff) begin
         vec_wr_en   = 1'b1;
         vec_wr_addr = VW'(cp_idx_ff);
         vec_wr_re   = cp_data_ff[2*VAL_W-1:VAL_W];
         vec_wr_im   = cp_data_ff[VAL_W-1:0];
      end else begin
         vec_wr_en   = cmd.load_vector && load_row_ok;
         vec_wr_addr = VW'(req_row_index);
         vec_wr_re   = req_value_re;
         vec_wr_im   = req_value_im;
      end
   end

   // Matrix memory.
   always_ff @(posedge clock) begin
      if (mat_wr_en) begin
         matrix_mem[mat_wr_addr] <= req_value_re;
      end
      a_m_ff <= matrix_mem[mat_rd_addr];
   end

   // Vector memories.
   always_ff @(posedge clock) begin
      if (vec_wr_en) begin
         vec_re_mem[vec_wr_addr] <= vec_wr_re;
         vec_im_mem[vec_wr_addr] <= vec_wr_im;
      end
      a_vre_ff <= vec_re_mem[VW'(cmd.mac_col)];
      a_vim_ff <= vec_im_mem[VW'(cmd.mac_col)];
   end

   // A result leaves the accumulator once the response register is free.
   assign transfer = acc_done_ff && (!out_valid_ff || rsp_ready);
   assign status.row_taken = transfer;

   // Accumulate products; the first column of a row starts from zero.
   always_comb begin
      acc_re_in   = acc_re_ff;
      acc_im_in   = acc_im_ff;
      acc_done_in = acc_done_ff && !transfer;
      if (b_valid_ff) begin
         acc_re_in = (b_first_ff ? '0 : acc_re_ff) + ACC_W'(b_pre_ff);
         acc_im_in = (b_first_ff ? '0 : acc_im_ff) + ACC_W'(b_pim_ff);
         if (b_last_col_ff) begin
            acc_done_in = 1'b1;
         end
      end
   end

   assign out_valid_in = transfer || (out_valid_ff && !rsp_ready);

   // Staging store of rounded results, then the sweep back into the vector.
   always_ff @(posedge clock) begin
      if (transfer) begin
         stage_mem[SW'(acc_row_ff)] <= {round_sat(acc_re_ff), round_sat(acc_im_ff)};
      end
      cp_data_ff <= stage_mem[SW'(cmd.copy_idx)];
      cp_idx_ff  <= cmd.copy_idx;
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      a_first_ff      <= cmd.mac_first;
      a_last_col_ff   <= cmd.mac_last_col;
      a_last_row_ff   <= cmd.mac_last_row;
      a_row_ff        <= cmd.mac_row;
      b_pre_ff        <= a_m_ff * a_vre_ff;
      b_pim_ff        <= a_m_ff * a_vim_ff;
      b_first_ff      <= a_first_ff;
      b_last_col_ff   <= a_last_col_ff;
      b_last_row_ff   <= a_last_row_ff;
      b_row_ff        <= a_row_ff;
      acc_re_ff       <= acc_re_in;
      acc_im_ff       <= acc_im_in;
      if (b_valid_ff) begin
         acc_row_ff      <= b_row_ff;
         acc_last_row_ff <= b_last_row_ff;
      end
      if (transfer) begin
         out_index_ff <= acc_row_ff;
         out_re_ff    <= acc_re_ff;
         out_im_ff    <= acc_im_ff;
         out_last_ff  <= acc_last_row_ff;
      end
   end

   // Pipeline control.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         acc_done_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cp_valid_ff  <= 1'b0;
      end else begin
         a_valid_ff   <= cmd.mac_valid;
         b_valid_ff   <= a_valid_ff;
         acc_done_ff  <= acc_done_in;
         out_valid_ff <= out_valid_in;
         cp_valid_ff  <= cmd.copy_valid;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_index = out_index_ff;
   assign rsp_out_re    = out_re_ff;
   assign rsp_out_im    = out_im_ff;
   assign rsp_out_last  = out_last_ff;

   // A new row never reaches the accumulator while a finished one waits.
   assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> !acc_done_ff)
      else $error("mvp_datapath: accumulator overrun");

   // A finished row stays put while the response register is held.
   assert property (@(posedge clock) disable iff (reset)
      (acc_done_ff && out_valid_ff && !rsp_ready) |=> acc_done_ff)
      else $error("mvp_datapath: finished row lost under stall");

   // Every hand-off fills the response register.
   assert property (@(posedge clock) disable iff (reset)
      transfer |=> out_valid_ff)
      else $error("mvp_datapath: hand-off did not load response");

endmodule

### hdl/real_matrix_complex_vector_product_core.sv
// ----------------------------------------------------------------------------
// real_matrix_complex_vector_product_core
// Multiplies a stored real Q4.12 matrix, or its transpose, onto a stored
// complex Q4.12 vector, streams exact Q14.24 results and writes them back
// rounded and saturated into the vector.
//
//   Channel   Direction  Handshake              Contents
//   req_ch    in         valid/ready            cmd, row/col index, value re/im
//   rsp_ch    out        valid/ready            out_index, out_re/im, out_last
//   csr_*     in         write enable only      size_in_use, transpose_mode
//
// Load requests are taken back to back while idle. After a compute of size n
// is taken, the request side stays busy: each row issues n multiply-accumulates,
// then waits for the pipeline to hand it over, and a sweep over the n entries
// plus a flush state copies the rounded results back.
// Reset is synchronous and clears control state; the stores hold no reset value.
// A stalled response channel holds the next row in the accumulator and pauses.
// ----------------------------------------------------------------------------
module real_matrix_complex_vector_product_core #(
   parameter int MAX_SIZE = mvp_pkg::DEFAULT_MAX_SIZE
) (
   input  logic                               clock,
   input  logic                               reset,
   mvp_req_if.sink                            req_ch,
   mvp_rsp_if.source                          rsp_ch,
   input  logic                               csr_write_enable,
   input  logic [mvp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mvp_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   mvp_pkg::ctl_cmd_type     ctl_cmd;
   mvp_pkg::dp_status_type   dp_status;
   logic                     req_ready;

   assign req_ch.ready = req_ready;

   // Controller.
   mvp_ctrl #(
      .MAX_SIZE (MAX_SIZE)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_cmd          (req_ch.cmd),
      .req_ready        (req_ready),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (ctl_cmd),
      .status           (dp_status)
   );

   // Datapath.
   mvp_datapath #(
      .MAX_SIZE (MAX_SIZE)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (ctl_cmd),
      .status         (dp_status),
      .req_row_index  (req_ch.row_index),
      .req_col_index  (req_ch.col_index),
      .req_value_re   (req_ch.value_re),
      .req_value_im   (req_ch.value_im),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_out_index  (rsp_ch.out_index),
      .rsp_out_re     (rsp_ch.out_re),
      .rsp_out_im     (rsp_ch.out_im),
      .rsp_out_last   (rsp_ch.out_last)
   );

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the real matrix by complex vector product core.
// A short table of directed requests is followed by randomized phases of
// loads and computes. Every result element is compared with an in-bench
// prediction of the exact Q14.24 sums and of the rounded write-back into the
// vector. Both channels idle at random, and control writes happen between
// phases once the core has gone quiet.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Widths and codes of the core.
   localparam int CMD_W       = mvp_pkg::CMD_W;
   localparam int IDX_W       = mvp_pkg::IDX_W;
   localparam int VAL_W       = mvp_pkg::VAL_W;
   localparam int ACC_W       = mvp_pkg::ACC_W;
   localparam int SIZE_W      = mvp_pkg::SIZE_W;
   localparam int CSR_IDX_W   = mvp_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W  = mvp_pkg::CSR_DATA_W;
   localparam int INDEX_LIMIT = mvp_pkg::INDEX_LIMIT;

   localparam logic [CMD_W-1:0] CMD_LOAD_MATRIX = mvp_pkg::CMD_LOAD_MATRIX;
   localparam logic [CMD_W-1:0] CMD_LOAD_VECTOR = mvp_pkg::CMD_LOAD_VECTOR;
   localparam logic [CMD_W-1:0] CMD_COMPUTE     = mvp_pkg::CMD_COMPUTE;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_IN_USE    = mvp_pkg::CSR_SIZE_IN_USE;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPOSE_MODE = mvp_pkg::CSR_TRANSPOSE_MODE;

   // Command code that the core must ignore.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic signed [VAL_W-1:0] Q_ONE = 16'sh1000;
   localparam logic signed [VAL_W-1:0] Q_MAX = 16'sh7FFF;
   localparam logic signed [VAL_W-1:0] Q_MIN = 16'sh8000;

   // Settling wait that lets the write-back sweep of a full size compute end.
   localparam int SETTLE_CYCLES  = 40;
   localparam int END_CYCLES     = 60;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 420;
   localparam int DIR_STEPS      = 25;

   typedef struct packed {
      logic [IDX_W-1:0]        index;
      logic signed [ACC_W-1:0] re;
      logic signed [ACC_W-1:0] im;
      logic                    last;
   } element_type;

   typedef enum {DIR_REQ, DIR_SIZE, DIR_TRANSPOSE} dir_kind_type;

   typedef struct {
      dir_kind_type            kind;
      logic [SIZE_W-1:0]       setting;
      logic [CMD_W-1:0]        cmd;
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [VAL_W-1:0] re;
      logic signed [VAL_W-1:0] im;
      bit                      checked;
      logic signed [ACC_W-1:0] want_re;
      logic signed [ACC_W-1:0] want_im;
   } dir_step_type;

   logic clock = 1'b0;
   logic reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   mvp_req_if req_bus ();
   mvp_rsp_if rsp_bus ();

   real_matrix_complex_vector_product_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_bus),
      .rsp_ch           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the stores and controls, at the default store size.
   logic signed [VAL_W-1:0] mat_shadow [INDEX_LIMIT][INDEX_LIMIT];
   logic signed [VAL_W-1:0] vec_re_shadow [INDEX_LIMIT];
   logic signed [VAL_W-1:0] vec_im_shadow [INDEX_LIMIT];
   bit                      mat_loaded [INDEX_LIMIT][INDEX_LIMIT];
   bit                      vec_loaded [INDEX_LIMIT];
   logic [SIZE_W-1:0]       size_shadow = SIZE_W'(mvp_pkg::SIZE_RESET);
   bit                      transpose_shadow = 1'b0;

   element_type pending_elements [$];

   int  failures = 0;
   int  accepted_items = 0;
   int  computes = 0;
   int  checked_elements = 0;
   int  settings = 0;
   int  quiet_cycles;
   bit  calm = 1'b0;

   int  size_plan [7] = '{4, 16, 1, 31, 0, 3, 17};

   // Directed requests; a listed expectation stands for a one element compute.
   dir_step_type directed_steps [DIR_STEPS] = '{
      // Size one: unit entry onto the vector extremes, twice over.
      '{DIR_SIZE, 1, CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0},
      '{DIR_REQ, 0, CMD_LOAD_MATRIX, 0, 0, Q_ONE, 16'sh5A5A, 0, 0, 0},
      '{DIR_REQ, 0, CMD_LOAD_VECTOR, 0, 0, Q_MAX, Q_MIN, 0, 0, 0},
      '{DIR_REQ, 0, CMD_COMPUTE, 0, 0, 0, 0, 1, 38'sd134213632, -38'sd134217728},
      '{DIR_REQ, 0, CMD_COMPUTE, 0, 0, 0, 0, 1, 38'sd134213632, -38'sd134217728},
      // Most negative entry; the written-back vector saturates.
      '{DIR_REQ, 0, CMD_LOAD_MATRIX, 0, 0, Q_MIN, 0, 0, 0, 0},
      '{DIR_REQ, 0, CMD_LOAD_VECTOR, 0, 0, Q_MIN, Q_MAX, 0, 0, 0},
      '{DIR_REQ, 0, CMD_COMPUTE, 0, 0, 0, 0, 1, 38'sd1073741824, -38'sd1073709056},
      '{DIR_REQ, 0, CMD_COMPUTE, 0, 0, 0, 0, 1, -38'sd1073709056, 38'sd1073741824},
      // Unused command, then a compute of size zero; neither gives a result.
      '{DIR_REQ, 0, CMD_UNUSED, 15, 15, -1, -1, 0, 0, 0},
      '{DIR_SIZE, 0, CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0},
      '{DIR_REQ, 0, CMD_COMPUTE, 0, 0, 0, 0, 0, 0, 0},
      // Size two, transposed, with entries stored beyond the size in use.
      '{DIR_SIZE, 2, CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0},
      '{DIR_TRANSPOSE, 1, CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0},
      '{DIR_REQ, 0, CMD_LOAD_MATRIX, 0, 1, 16'sh4000, 0, 0, 0, 0},
      '{DIR_REQ, 0, CMD_LOAD_MATRIX, 1, 0, 16'shC000, 0, 0, 0, 0},
      '{DIR_REQ, 0, CMD_LOAD_MATRIX, 1, 1, Q_MAX, 0, 0, 0, 0},
      '{DIR_REQ, 0, CMD_LOAD_VECTOR, 1, 0, 16'sh1234, 16'shEDCB, 0, 0, 0},
      '{DIR_REQ, 0, CMD_LOAD_MATRIX, 15, 15, Q_MAX, 0, 0, 0, 0},
      '{DIR_REQ, 0, CMD_LOAD_VECTOR, 15, 0, Q_MIN, Q_MAX, 0, 0, 0},
      '{DIR_REQ, 0, CMD_COMPUTE, 0, 0, 0, 0, 0, 0, 0},
      '{DIR_TRANSPOSE, 0, CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0},
      '{DIR_REQ, 0, CMD_COMPUTE, 0, 0, 0, 0, 0, 0, 0},
      '{DIR_REQ, 0, CMD_LOAD_MATRIX, 0, 15, 16'sh0001, 0, 0, 0, 0},
      '{DIR_REQ, 0, CMD_COMPUTE, 0, 0, 0, 0, 0, 0, 0}
   };

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Prints one line per failure and counts it.
   task automatic note_failure(input string msg);
      $display("ERROR: %s", msg);
      failures++;
   endtask

   // Rounds a Q14.24 sum half up to Q4.12 and saturates it.
   function automatic logic signed [VAL_W-1:0] round_q412(input longint sum);
      longint q;
      q = (sum + 2048) >>> 12;
      if (q > 32767) begin
         q = 32767;
      end else if (q < -32768) begin
         q = -32768;
      end
      return q[VAL_W-1:0];
   endfunction

   // Applies one accepted request to the shadow state and queues the elements it yields.
   function automatic void predict_elements(input logic [CMD_W-1:0] cmd,
                                            input logic [IDX_W-1:0] row, col,
                                            input logic signed [VAL_W-1:0] re, im);
      longint      acc_re [INDEX_LIMIT];
      longint      acc_im [INDEX_LIMIT];
      longint      m;
      int          n;
      element_type e;
      case (cmd)
         CMD_LOAD_MATRIX: begin
            mat_shadow[row][col] = re;
            mat_loaded[row][col] = 1'b1;
         end
         CMD_LOAD_VECTOR: begin
            vec_re_shadow[row] = re;
            vec_im_shadow[row] = im;
            vec_loaded[row]    = 1'b1;
         end
         CMD_COMPUTE: begin
            n = (size_shadow > INDEX_LIMIT) ? INDEX_LIMIT : size_shadow;
            // All rows are summed before any of them is written back.
            for (int r = 0; r < n; r++) begin
               acc_re[r] = 0;
               acc_im[r] = 0;
               for (int c = 0; c < n; c++) begin
                  m = transpose_shadow ? mat_shadow[c][r] : mat_shadow[r][c];
                  acc_re[r] += m * vec_re_shadow[c];
                  acc_im[r] += m * vec_im_shadow[c];
               end
            end
            for (int r = 0; r < n; r++) begin
               e.index = IDX_W'(r);
               e.re    = acc_re[r][ACC_W-1:0];
               e.im    = acc_im[r][ACC_W-1:0];
               e.last  = (r == n - 1);
               pending_elements.push_back(e);
               vec_re_shadow[r] = round_q412(acc_re[r]);
               vec_im_shadow[r] = round_q412(acc_im[r]);
            end
         end
         default: begin
         end
      endcase
   endfunction

   // Mostly random values, with the two extremes now and then.
   function automatic logic signed [VAL_W-1:0] pick_value();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         return Q_MIN;
      end
      if (pick < 16) begin
         return Q_MAX;
      end
      return VAL_W'($urandom);
   endfunction

   // Offers one request, after an optional random gap, and waits until it is taken.
   task automatic send_request(input logic [CMD_W-1:0] cmd,
                               input logic [IDX_W-1:0] row, col,
                               input logic signed [VAL_W-1:0] re, im);
      if (!calm) begin
         while ($urandom_range(99) < 10) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= cmd;
      req_bus.row_index <= row;
      req_bus.col_index <= col;
      req_bus.value_re  <= re;
      req_bus.value_im  <= im;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) begin
         @(posedge clock);
      end
      predict_elements(cmd, row, col, re, im);
      if (cmd != CMD_UNUSED) begin
         accepted_items++;
      end
      if (cmd == CMD_COMPUTE) begin
         computes++;
      end
   endtask

   // A random matrix or vector load with indexes below the given limit.
   task automatic send_random_load(input int lim);
      if ($urandom_range(1)) begin
         send_request(CMD_LOAD_MATRIX, IDX_W'($urandom_range(lim - 1)),
                      IDX_W'($urandom_range(lim - 1)), pick_value(), VAL_W'($urandom));
      end else begin
         send_request(CMD_LOAD_VECTOR, IDX_W'($urandom_range(lim - 1)), IDX_W'($urandom),
                      pick_value(), pick_value());
      end
   endtask

   // Loads every entry that a compute of size n reads and that was never written.
   task automatic fill_missing(input int n);
      for (int r = 0; r < n; r++) begin
         if (!vec_loaded[r]) begin
            send_request(CMD_LOAD_VECTOR, IDX_W'(r), IDX_W'($urandom), pick_value(),
                         pick_value());
         end
         for (int c = 0; c < n; c++) begin
            if (!mat_loaded[r][c]) begin
               send_request(CMD_LOAD_MATRIX, IDX_W'(r), IDX_W'(c), pick_value(),
                            VAL_W'($urandom));
            end
         end
      end
   endtask

   // Waits until every element has arrived, then for the settling wait, then writes controls.
   task automatic configure(input bit set_size, input logic [SIZE_W-1:0] size_val,
                            input bit set_tr, input bit tr_val);
      req_bus.valid <= 1'b0;
      while (pending_elements.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (set_size) begin
         csr_write_enable <= 1'b1;
         csr_index        <= CSR_SIZE_IN_USE;
         csr_write_data   <= size_val;
         @(posedge clock);
         size_shadow = size_val;
      end
      if (set_tr) begin
         csr_write_enable <= 1'b1;
         csr_index        <= CSR_TRANSPOSE_MODE;
         csr_write_data   <= CSR_DATA_W'(tr_val);
         @(posedge clock);
         transpose_shadow = tr_val;
      end
      csr_write_enable <= 1'b0;
      settings++;
   endtask

   // Result side: random stalls, and each element checked against the oldest prediction.
   always @(posedge clock) begin
      element_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            checked_elements++;
            if (pending_elements.size() == 0) begin
               note_failure($sformatf("unexpected result element, index %0d",
                                      rsp_bus.out_index));
            end else begin
               want = pending_elements.pop_front();
               if (rsp_bus.out_index !== want.index) begin
                  note_failure($sformatf("element index %0d, expected %0d",
                                         rsp_bus.out_index, want.index));
               end
               if (rsp_bus.out_re !== want.re) begin
                  note_failure($sformatf("element %0d real part %0d, expected %0d",
                                         want.index, rsp_bus.out_re, $signed(want.re)));
               end
               if (rsp_bus.out_im !== want.im) begin
                  note_failure($sformatf("element %0d imaginary part %0d, expected %0d",
                                         want.index, rsp_bus.out_im, $signed(want.im)));
               end
               if (rsp_bus.out_last !== want.last) begin
                  note_failure($sformatf("element %0d last mark %0b, expected %0b",
                                         want.index, rsp_bus.out_last, want.last));
               end
            end
         end
         rsp_bus.ready <= calm || ($urandom_range(99) >= 10);
      end
   end

   // Watchdog: ends the run when neither channel has moved for too long.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
                   (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("ERROR: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Stimulus: reset, the directed table, randomized phases, then the drain.
   initial begin
      element_type       listed;
      int                phase;
      int                pick;
      int                used;
      int                done;
      int                start_items;
      logic [SIZE_W-1:0] next_size;

      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.cmd       = CMD_LOAD_MATRIX;
      req_bus.row_index = '0;
      req_bus.col_index = '0;
      req_bus.value_re  = '0;
      req_bus.value_im  = '0;
      csr_write_enable  = 1'b0;
      csr_index         = CSR_SIZE_IN_USE;
      csr_write_data    = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table; listed rows replace the prediction with the typed-in value.
      foreach (directed_steps[i]) begin
         case (directed_steps[i].kind)
            DIR_SIZE: begin
               configure(1'b1, directed_steps[i].setting, 1'b0, 1'b0);
            end
            DIR_TRANSPOSE: begin
               configure(1'b0, '0, 1'b1, directed_steps[i].setting[0]);
            end
            default: begin
               send_request(directed_steps[i].cmd, directed_steps[i].row,
                            directed_steps[i].col, directed_steps[i].re,
                            directed_steps[i].im);
               if (directed_steps[i].checked) begin
                  void'(pending_elements.pop_back());
                  listed.index = '0;
                  listed.re    = directed_steps[i].want_re;
                  listed.im    = directed_steps[i].want_im;
                  listed.last  = 1'b1;
                  pending_elements.push_back(listed);
               end
            end
         endcase
      end

      // Randomized phases: new controls, then bursts of loads each closed by computes.
      start_items = accepted_items;
      phase = 0;
      while (accepted_items - start_items < RANDOM_ITEMS) begin
         if (phase < $size(size_plan)) begin
            configure(1'b1, SIZE_W'(size_plan[phase]), 1'b1, phase[0]);
         end else begin
            pick = $urandom_range(99);
            if (pick < 5) begin
               next_size = '0;
            end else if (pick < 75) begin
               next_size = SIZE_W'($urandom_range(1, 6));
            end else if (pick < 90) begin
               next_size = SIZE_W'($urandom_range(7, 16));
            end else begin
               next_size = SIZE_W'($urandom_range(17, 31));
            end
            pick = $urandom_range(3);
            configure(pick != 1, next_size, pick != 0, 1'($urandom_range(1)));
         end
         used = (size_shadow > INDEX_LIMIT) ? INDEX_LIMIT : size_shadow;
         repeat ($urandom_range(2, 4)) begin
            // A stretch in the middle of the run goes without any idling.
            done = accepted_items - start_items;
            calm = (done >= 150 && done < 260);
            repeat ($urandom_range(0, 2 * used + 2)) begin
               if ($urandom_range(99) < 85) begin
                  send_random_load((used == 0) ? 1 : used);
               end else if ($urandom_range(1)) begin
                  send_request(CMD_UNUSED, IDX_W'($urandom), IDX_W'($urandom),
                               VAL_W'($urandom), VAL_W'($urandom));
               end else begin
                  send_random_load(INDEX_LIMIT);
               end
            end
            fill_missing(used);
            repeat ($urandom_range(1, 2)) begin
               send_request(CMD_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), pick_value(),
                            pick_value());
            end
         end
         phase++;
      end
      calm = 1'b0;

      // Drain: every predicted element, then a quiet tail that catches stray ones.
      req_bus.valid <= 1'b0;
      while (pending_elements.size() != 0) begin
         @(posedge clock);
      end
      repeat (END_CYCLES) @(posedge clock);

      $display("Ran %0d requests including %0d computes; checked %0d result elements.",
               accepted_items, computes, checked_elements);
      $display("Controls were set %0d times, over sizes 0 to 31 and both transpose modes.",
               settings);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### sim.f
hdl/mvp_pkg.sv
hdl/mvp_req_if.sv
hdl/mvp_rsp_if.sv
hdl/mvp_ctrl.sv
hdl/mvp_datapath.sv
hdl/real_matrix_complex_vector_product_core.sv
bench/testbench.sv
